// ----- hw/rtl/msort_pkg.sv -----
// Shared types and constants for the merge sort engine.
package msort_pkg;

   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int IDX_W_DEF        = $clog2(MAX_ELEMENTS_DEF);
   localparam int STK_DEPTH_DEF    = IDX_W_DEF + 1;

   localparam int VALUE_W = 32;
   localparam int CMP_W   = 9;
   localparam int LVL_W   = 3;

   localparam logic [CMP_W-1:0] CMP_LIMIT = '1;
   localparam logic [LVL_W-1:0] LVL_LIMIT = '1;

   // progress of one segment on the split stack
   typedef enum logic [1:0] {
      PH_NEW,
      PH_LEFT_DONE,
      PH_RIGHT_DONE
   } phase_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      set_phase;
      phase_type phase;
      logic      clear;
   } stk_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_VISIT,
      ST_COPY,
      ST_HEAD_I,
      ST_HEAD_J,
      ST_HEAD_W,
      ST_MERGE,
      ST_FILL,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

endpackage

// ----- hw/rtl/msort_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msort_ram #(
   parameter int WIDTH = msort_pkg::VALUE_W,
   parameter int DEPTH = msort_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/msort_stack.sv -----
// Segment stack that replaces the split recursion, with depth tracking.
module msort_stack #(
   parameter int DEPTH = msort_pkg::STK_DEPTH_DEF,
   parameter int IDX_W = msort_pkg::IDX_W_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msort_pkg::stk_op_type        op,
   input  logic [IDX_W-1:0]             push_lo,
   input  logic [IDX_W-1:0]             push_hi,
   output logic [IDX_W-1:0]             top_lo,
   output logic [IDX_W-1:0]             top_hi,
   output msort_pkg::phase_type         top_phase,
   output logic                         single,
   output logic [msort_pkg::LVL_W-1:0]  deepest
);
   import msort_pkg::*;

   localparam int DW = $clog2(DEPTH);
   localparam int SW = $clog2(DEPTH + 1);
   localparam int LW = SW + 1;

   logic [IDX_W-1:0] lo_ff [DEPTH];
   logic [IDX_W-1:0] hi_ff [DEPTH];
   phase_type        ph_ff [DEPTH];

   logic [SW-1:0]    sp_ff, sp_in;
   logic [LVL_W-1:0] deep_ff, deep_in;
   logic [DW-1:0]    top_idx, push_idx;
   logic [LW-1:0]    new_level;
   logic [LVL_W-1:0] level_sat;

   assign top_idx   = DW'(sp_ff - 1'b1);
   assign push_idx  = DW'(sp_ff);
   assign new_level = LW'(sp_ff) + 1'b1;
   assign level_sat = (new_level > LW'(LVL_LIMIT)) ? LVL_LIMIT : LVL_W'(new_level);

   always_comb begin
      sp_in   = sp_ff;
      deep_in = deep_ff;
      if (op.clear) begin
         deep_in = '0;
      end
      if (op.push) begin
         sp_in = sp_ff + 1'b1;
         if (level_sat > deep_ff) begin
            deep_in = level_sat;
         end
      end else if (op.pop) begin
         sp_in = sp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff   <= '0;
         deep_ff <= '0;
      end else begin
         sp_ff   <= sp_in;
         deep_ff <= deep_in;
      end
   end

   // entries carry no reset; only slots below the pointer are ever read
   always_ff @(posedge clock) begin
      if (op.set_phase) begin
         ph_ff[top_idx] <= op.phase;
      end
      if (op.push) begin
         lo_ff[push_idx] <= push_lo;
         hi_ff[push_idx] <= push_hi;
         ph_ff[push_idx] <= PH_NEW;
      end
   end

   assign top_lo    = lo_ff[top_idx];
   assign top_hi    = hi_ff[top_idx];
   assign top_phase = ph_ff[top_idx];
   assign single    = (sp_ff == SW'(1));
   assign deepest   = deep_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      op.push |-> sp_ff < SW'(DEPTH))
      else $error("segment stack pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      op.pop |-> sp_ff != '0)
      else $error("segment stack popped while empty");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      op.push |-> !op.pop && !op.clear)
      else $error("segment stack push collides with pop or clear");

endmodule

// ----- hw/rtl/merge_sort_engine.sv -----
// Merge sort engine top level: load, top-down merge sort, sorted readout.
//
// Input beats (req_value, req_last) are written into the element store, one
// per cycle while req_ready is high. Beats beyond MAX_ELEMENTS are dropped
// and the run is flagged in rsp_dropped. A beat with req_last set starts the
// sort; req_ready stays low until the last result has been loaded into the
// output register.
// The sort walks the split tree with a segment stack. Each merge copies the
// segment into the scratch RAM (one element per cycle), primes both heads
// through ST_HEAD_I, ST_HEAD_J and ST_HEAD_W and then writes the merged
// elements, each merge write followed by a head refill, bounded by the single
// scratch read port. The readout does one store read and one output load per
// result while the receiver keeps up.
// Every result carries the comparison count, the deepest split level and the
// drop flag of its run; rsp_end_of_run marks the final element.
// A stalled receiver holds the output register and halts the readout; the
// next load begins once the final result sits in the output register.
// Reset is synchronous; it empties the store count, the stack and the output.
module merge_sort_engine #(
   parameter int MAX_ELEMENTS = msort_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [msort_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [msort_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                               rsp_end_of_run,
   output logic [msort_pkg::CMP_W-1:0]        rsp_compare_total,
   output logic [msort_pkg::LVL_W-1:0]        rsp_deepest_level,
   output logic                               rsp_dropped
);
   import msort_pkg::*;

   localparam int IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int STK_DEPTH = IDX_W + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CMP_W-1:0] cmp_ff, cmp_in;
   logic [IDX_W-1:0] t_ff, t_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] q_ff, q_in;
   logic signed [VALUE_W-1:0] head_i_ff, head_i_in;
   logic signed [VALUE_W-1:0] head_j_ff, head_j_in;
   logic             take_left_ff, take_left_in;
   logic             cp_wr_ff, cp_wr_in;
   logic [IDX_W-1:0] cp_addr_ff, cp_addr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [CMP_W-1:0] rsp_cmp_ff, rsp_cmp_in;
   logic [LVL_W-1:0] rsp_deep_ff, rsp_deep_in;
   logic             rsp_drop_ff, rsp_drop_in;

   logic               st_we;
   logic [IDX_W-1:0]   st_waddr, st_raddr;
   logic [VALUE_W-1:0] st_wdata, st_rdata;
   logic [IDX_W-1:0]   sc_raddr;
   logic [VALUE_W-1:0] sc_rdata;

   stk_op_type       stk_op;
   logic [IDX_W-1:0] stk_push_lo, stk_push_hi;
   logic [IDX_W-1:0] top_lo, top_hi;
   phase_type        top_phase;
   logic             stk_single;
   logic [LVL_W-1:0] stk_deepest;

   logic [IDX_W-1:0]   mid_calc;
   logic               left_ok, right_ok, take_left;
   logic [VALUE_W-1:0] taken;
   logic               out_last;

   msort_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   msort_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_scratch (
      .clock (clock),
      .we    (cp_wr_ff),
      .waddr (cp_addr_ff),
      .wdata (st_rdata),
      .raddr (sc_raddr),
      .rdata (sc_rdata)
   );

   msort_stack #(
      .DEPTH (STK_DEPTH),
      .IDX_W (IDX_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .op        (stk_op),
      .push_lo   (stk_push_lo),
      .push_hi   (stk_push_hi),
      .top_lo    (top_lo),
      .top_hi    (top_hi),
      .top_phase (top_phase),
      .single    (stk_single),
      .deepest   (stk_deepest)
   );

   assign mid_calc  = top_lo + ((top_hi - top_lo) >> 1);
   assign left_ok   = (i_ff <= mid_ff);
   assign right_ok  = (j_ff <= CNT_W'(hi_ff));
   // ties go to the left half to keep the merge stable
   assign take_left = left_ok && (!right_ok || (head_i_ff <= head_j_ff));
   assign taken     = take_left ? head_i_ff : head_j_ff;
   assign out_last  = ((CNT_W'(q_ff) + 1'b1) == cnt_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      cmp_in       = cmp_ff;
      t_in         = t_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      q_in         = q_ff;
      head_i_in    = head_i_ff;
      head_j_in    = head_j_ff;
      take_left_in = take_left_ff;
      cp_wr_in     = 1'b0;
      cp_addr_in   = t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_deep_in  = rsp_deep_ff;
      rsp_drop_in  = rsp_drop_ff;
      st_we        = 1'b0;
      st_waddr     = k_ff;
      st_wdata     = taken;
      st_raddr     = q_ff;
      sc_raddr     = i_ff;
      stk_op       = '0;
      stk_push_lo  = top_lo;
      stk_push_hi  = mid_calc;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cnt_ff < CNT_W'(MAX_ELEMENTS)) begin
                  st_we    = 1'b1;
                  st_waddr = IDX_W'(cnt_ff);
                  st_wdata = req_value;
                  cnt_in   = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            stk_op.push = 1'b1;
            stk_push_lo = '0;
            stk_push_hi = IDX_W'(cnt_ff - 1'b1);
            state_in    = ST_VISIT;
         end
         ST_VISIT: begin
            unique case (top_phase)
               PH_NEW: begin
                  if (top_lo < top_hi) begin
                     stk_op.set_phase = 1'b1;
                     stk_op.phase     = PH_LEFT_DONE;
                     stk_op.push      = 1'b1;
                  end else begin
                     stk_op.pop = 1'b1;
                     if (stk_single) begin
                        q_in     = '0;
                        state_in = ST_OUT_RD;
                     end
                  end
               end
               PH_LEFT_DONE: begin
                  stk_op.set_phase = 1'b1;
                  stk_op.phase     = PH_RIGHT_DONE;
                  stk_op.push      = 1'b1;
                  stk_push_lo      = mid_calc + 1'b1;
                  stk_push_hi      = top_hi;
               end
               PH_RIGHT_DONE: begin
                  t_in     = top_lo;
                  i_in     = top_lo;
                  j_in     = CNT_W'(mid_calc) + 1'b1;
                  k_in     = top_lo;
                  mid_in   = mid_calc;
                  hi_in    = top_hi;
                  state_in = ST_COPY;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_COPY: begin
            st_raddr   = t_ff;
            cp_wr_in   = 1'b1;
            cp_addr_in = t_ff;
            t_in       = t_ff + 1'b1;
            if (t_ff == hi_ff) begin
               state_in = ST_HEAD_I;
            end
         end
         ST_HEAD_I: begin
            sc_raddr = i_ff;
            state_in = ST_HEAD_J;
         end
         ST_HEAD_J: begin
            head_i_in = sc_rdata;
            sc_raddr  = IDX_W'(j_ff);
            state_in  = ST_HEAD_W;
         end
         ST_HEAD_W: begin
            head_j_in = sc_rdata;
            state_in  = ST_MERGE;
         end
         ST_MERGE: begin
            st_we        = 1'b1;
            take_left_in = take_left;
            if (left_ok && right_ok && (cmp_ff != CMP_LIMIT)) begin
               cmp_in = cmp_ff + 1'b1;
            end
            if (take_left) begin
               i_in     = i_ff + 1'b1;
               sc_raddr = i_ff + 1'b1;
            end else begin
               j_in     = j_ff + 1'b1;
               sc_raddr = IDX_W'(j_ff + 1'b1);
            end
            if (k_ff == hi_ff) begin
               stk_op.pop = 1'b1;
               if (stk_single) begin
                  q_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  state_in = ST_VISIT;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (take_left_ff) begin
               head_i_in = sc_rdata;
            end else begin
               head_j_in = sc_rdata;
            end
            state_in = ST_MERGE;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = st_rdata;
               rsp_last_in  = out_last;
               rsp_cmp_in   = cmp_ff;
               rsp_deep_in  = stk_deepest;
               rsp_drop_in  = ovf_ff;
               if (out_last) begin
                  cnt_in       = '0;
                  ovf_in       = 1'b0;
                  cmp_in       = '0;
                  stk_op.clear = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  q_in     = q_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         cmp_ff       <= '0;
         cp_wr_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         cmp_ff       <= cmp_in;
         cp_wr_ff     <= cp_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      q_ff         <= q_in;
      head_i_ff    <= head_i_in;
      head_j_ff    <= head_j_in;
      take_left_ff <= take_left_in;
      cp_addr_ff   <= cp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_deep_ff  <= rsp_deep_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_value  = rsp_value_ff;
   assign rsp_end_of_run    = rsp_last_ff;
   assign rsp_compare_total = rsp_cmp_ff;
   assign rsp_deepest_level = rsp_deep_ff;
   assign rsp_dropped       = rsp_drop_ff;

   a_merge_in_segment: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> k_ff <= hi_ff)
      else $error("merge write ran past the segment end");

   a_merge_has_source: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> (i_ff <= mid_ff) || (j_ff <= CNT_W'(hi_ff)))
      else $error("merge step with both halves exhausted");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above capacity");

   a_copy_drains: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HEAD_I |-> cp_wr_ff && (cp_addr_ff == hi_ff))
      else $error("scratch copy not finishing at segment end");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for merge_sort_engine: directed rows, then random sort runs.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import msort_pkg::*;

   localparam int CAPACITY     = MAX_ELEMENTS_DEF;
   localparam int RANDOM_ITEMS = 340;
   localparam int N_ROWS       = 22;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      end_of_run;
      logic [CMP_W-1:0]          compare_total;
      logic [LVL_W-1:0]          deepest_level;
      logic                      dropped;
   } sorted_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      typed;
      sorted_beat_type           result;
   } stim_row_type;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   // single-element runs have an obvious result: no compares, depth one
   stim_row_type stim_rows [0:N_ROWS-1] = '{
      '{VAL_MAX, 1'b1, 1'b1, '{VAL_MAX, 1'b1, 9'd0, 3'd1, 1'b0}},
      '{VAL_MIN, 1'b1, 1'b1, '{VAL_MIN, 1'b1, 9'd0, 3'd1, 1'b0}},
      '{32'sd0,  1'b1, 1'b1, '{32'sd0,  1'b1, 9'd0, 3'd1, 1'b0}},
      '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 9'd0, 3'd1, 1'b0}},
      '{32'sd5,  1'b0, 1'b0, '0},
      '{-32'sd3, 1'b1, 1'b0, '0},
      '{VAL_MAX, 1'b0, 1'b0, '0},
      '{VAL_MIN, 1'b0, 1'b0, '0},
      '{-32'sd1, 1'b0, 1'b0, '0},
      '{32'sd0,  1'b0, 1'b0, '0},
      '{32'sd1,  1'b1, 1'b0, '0},
      '{32'sd4,  1'b0, 1'b0, '0},
      '{32'sd3,  1'b0, 1'b0, '0},
      '{32'sd2,  1'b0, 1'b0, '0},
      '{32'sd1,  1'b1, 1'b0, '0},
      '{32'sd7,  1'b0, 1'b0, '0},
      '{32'sd7,  1'b0, 1'b0, '0},
      '{-32'sd7, 1'b0, 1'b0, '0},
      '{32'sd7,  1'b1, 1'b0, '0},
      '{32'sd10, 1'b0, 1'b0, '0},
      '{32'sd20, 1'b0, 1'b0, '0},
      '{32'sd30, 1'b1, 1'b0, '0}
   };

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_sorted_value;
   logic                      rsp_end_of_run;
   logic [CMP_W-1:0]          rsp_compare_total;
   logic [LVL_W-1:0]          rsp_deepest_level;
   logic                      rsp_dropped;

   // typed expectation travelling with the current request beat
   logic                      row_typed  = 1'b0;
   sorted_beat_type           row_result = '0;

   int                        send_idle_pct = 0;
   int                        stall_pct     = 0;
   int                        mismatches    = 0;

   // predictor state
   logic signed [VALUE_W-1:0] held_vals    [CAPACITY];
   logic signed [VALUE_W-1:0] scratch_vals [CAPACITY];
   int                        held_count     = 0;
   logic [CMP_W-1:0]          merge_compares = '0;
   logic [LVL_W-1:0]          deepest_split  = '0;
   logic                      spill_seen     = 1'b0;
   sorted_beat_type           sorted_results [$];

   merge_sort_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_compare_total (rsp_compare_total),
      .rsp_deepest_level (rsp_deepest_level),
      .rsp_dropped       (rsp_dropped)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // top-down split, then stable merge through the scratch copy
   function automatic void split_sort(int lo, int hi, int level);
      int mid, i, j, k;
      if (level > int'(LVL_LIMIT)) level = int'(LVL_LIMIT);
      if (level > int'(deepest_split)) deepest_split = LVL_W'(level);
      if (lo >= hi) return;
      mid = lo + (hi - lo) / 2;
      split_sort(lo, mid, level + 1);
      split_sort(mid + 1, hi, level + 1);
      for (k = lo; k <= hi; k++) scratch_vals[k] = held_vals[k];
      i = lo;
      j = mid + 1;
      k = lo;
      while (i <= mid && j <= hi) begin
         if (merge_compares < CMP_LIMIT) merge_compares++;
         if (scratch_vals[i] <= scratch_vals[j]) begin
            held_vals[k] = scratch_vals[i];
            i++;
         end else begin
            held_vals[k] = scratch_vals[j];
            j++;
         end
         k++;
      end
      while (i <= mid) begin
         held_vals[k] = scratch_vals[i];
         i++;
         k++;
      end
      while (j <= hi) begin
         held_vals[k] = scratch_vals[j];
         j++;
         k++;
      end
   endfunction

   function automatic void load_and_sort(logic signed [VALUE_W-1:0] v, logic l);
      sorted_beat_type beat;
      if (held_count < CAPACITY) begin
         held_vals[held_count] = v;
         held_count++;
      end else begin
         spill_seen = 1'b1;
      end
      if (!l) return;
      if (held_count > 0) split_sort(0, held_count - 1, 1);
      for (int k = 0; k < held_count; k++) begin
         beat.value         = held_vals[k];
         beat.end_of_run    = (k + 1 == held_count);
         beat.compare_total = merge_compares;
         beat.deepest_level = deepest_split;
         beat.dropped       = spill_seen;
         sorted_results.push_back(beat);
      end
      held_count     = 0;
      merge_compares = '0;
      deepest_split  = '0;
      spill_seen     = 1'b0;
   endfunction

   always @(posedge clock) begin
      int              queued;
      sorted_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queued = sorted_results.size();
            load_and_sort(req_value, req_last);
            // typed rows replace whatever was predicted for them
            if (row_typed) begin
               while (sorted_results.size() > queued) void'(sorted_results.pop_back());
               sorted_results.push_back(row_result);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%t: unexpected result beat value=%0d", $realtime, rsp_sorted_value);
            end else begin
               want = sorted_results.pop_front();
               if (rsp_sorted_value !== want.value || rsp_end_of_run !== want.end_of_run ||
                   rsp_compare_total !== want.compare_total ||
                   rsp_deepest_level !== want.deepest_level || rsp_dropped !== want.dropped) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%t: mismatch exp val=%0d end=%0b cmp=%0d lvl=%0d drop=%0b,",
                              $realtime, want.value, want.end_of_run, want.compare_total,
                              want.deepest_level, want.dropped,
                              " got val=%0d end=%0b cmp=%0d lvl=%0d drop=%0b",
                              rsp_sorted_value, rsp_end_of_run, rsp_compare_total,
                              rsp_deepest_level, rsp_dropped);
               end
            end
         end
      end
   end

   // drive one request beat from a falling edge; return at the falling edge after accept
   task automatic send_beat(logic signed [VALUE_W-1:0] v, logic l, logic typed,
                            sorted_beat_type result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_value  = v;
      req_last   = l;
      row_typed  = typed;
      row_result = result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int                        items_sent;
      int                        run_idx;
      int                        run_len;
      int                        pick;
      logic signed [VALUE_W-1:0] v;
      items_sent = 0;
      run_idx    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[r])
         send_beat(stim_rows[r].value, stim_rows[r].last, stim_rows[r].typed,
                   stim_rows[r].result);

      while (items_sent < RANDOM_ITEMS) begin
         // a few runs fill the store exactly or spill past it
         if (run_idx == 2) run_len = CAPACITY;
         else if (run_idx == 5) run_len = CAPACITY + 2;
         else if (run_idx == 9) run_len = CAPACITY + 1;
         else if ($urandom_range(99) < 8) run_len = $urandom_range(33, CAPACITY - 1);
         else run_len = $urandom_range(1, 12);
         if (run_len > RANDOM_ITEMS - items_sent) run_len = RANDOM_ITEMS - items_sent;
         for (int k = 0; k < run_len; k++) begin
            case (items_sent * 4 / RANDOM_ITEMS)
               0: begin send_idle_pct = 0;  stall_pct = 0;  end
               1: begin send_idle_pct = 67; stall_pct = 0;  end
               2: begin send_idle_pct = 0;  stall_pct = 67; end
               default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            pick = $urandom_range(99);
            if (pick < 20) v = $urandom_range(8) - 4;  // narrow range forces ties
            else if (pick < 30) begin
               case ($urandom_range(3))
                  0: v = VAL_MIN;
                  1: v = VAL_MAX;
                  2: v = 0;
                  default: v = -1;
               endcase
            end else v = $urandom;
            send_beat(v, k == run_len - 1, 1'b0, '0);
            items_sent++;
         end
         run_idx++;
      end
      req_valid = 1'b0;
      req_last  = 1'b0;

      while (sorted_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && sorted_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
